>>> rtl/core/assert_macros.svh
// assertion macros for the range minimum query engine
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/rmq_pkg.sv
// shared types and constants of the range minimum query engine
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 11;
  localparam int DATA_W = 32;
  localparam int RES_W  = 32;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_POP,
    S_A_CMP,
    S_A_WR,
    S_C_L0,
    S_C_L0D,
    S_LV_RD,
    S_LV_WR,
    S_IB_M,
    S_IB_V,
    S_IB_A,
    S_SP1,
    S_SP2,
    S_SP3,
    S_DONE
  } state_e;

endpackage

>>> rtl/core/rmq_store.sv
// value store and per-element stack mask store, one shared read address
// synchronous memories with registered read data; no package needed
`timescale 1ns / 1ps

module rmq_store #(
  parameter int AW = 10,
  parameter int VB = 32,
  parameter int MB = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [VB-1:0] wr_value_i,
  input  logic [MB-1:0] wr_mask_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [VB-1:0] rd_value_o,
  output logic [MB-1:0] rd_mask_o
);

  logic [VB-1:0] val_mem  [2**AW];
  logic [MB-1:0] mask_mem [2**AW];
  logic [VB-1:0] rd_value_q;
  logic [MB-1:0] rd_mask_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      val_mem[wr_addr_i]  <= wr_value_i;
      mask_mem[wr_addr_i] <= wr_mask_i;
    end
    rd_value_q <= val_mem[rd_addr_i];
    rd_mask_q  <= mask_mem[rd_addr_i];
  end

  assign rd_value_o = rd_value_q;
  assign rd_mask_o  = rd_mask_q;

endmodule

>>> rtl/core/rmq_sparse.sv
// sparse table of block minima, addressed by level and block
// synchronous memory with registered read data; no package needed
`timescale 1ns / 1ps

module rmq_sparse #(
  parameter int LW  = 3,
  parameter int NBW = 5,
  parameter int VB  = 32
) (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  logic [LW-1:0]  wr_level_i,
  input  logic [NBW-1:0] wr_block_i,
  input  logic [VB-1:0]  wr_data_i,
  input  logic [LW-1:0]  rd_level_i,
  input  logic [NBW-1:0] rd_block_i,
  output logic [VB-1:0]  rd_data_o
);

  logic [VB-1:0] sp_mem [2**(LW+NBW)];
  logic [VB-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sp_mem[{wr_level_i, wr_block_i}] <= wr_data_i;
    end
    rd_data_q <= sp_mem[{rd_level_i, rd_block_i}];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/range_minimum_query_engine_core.sv
// top level of the range minimum query engine: sequencer and datapath
// uses rmq_pkg, rmq_store and rmq_sparse
//
// channel   direction  signals
// request   in         start, command_i, value_i, left_i, right_i (busy is out)
// result    out        result_valid_o, minimum_o, status_o
//
// clear, no-op, full store, bad or empty range: result in the cycle after the request
// append: pops the stack through S_A_POP and S_A_CMP, one compare per popped entry plus one
//   when the stack is not emptied, then writes in S_A_WR; a finished block adds a level-0
//   write and each sparse level it completes, each a read-modify-write of the sparse memory
// query: dependent reads of the mask store then the value store, head and tail, with two
//   sparse reads between
// reset clears the state, count, running mask and result valid only; busy is high while a request is worked
`timescale 1ns / 1ps

module range_minimum_query_engine_core #(
  parameter int DEPTH      = 1024,
  parameter int BLOCK_BITS = 5,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [rmq_pkg::CMD_W-1:0]    command_i,
  input  logic [rmq_pkg::DATA_W-1:0]   value_i,
  input  logic [rmq_pkg::IDX_W-1:0]    left_i,
  input  logic [rmq_pkg::IDX_W-1:0]    right_i,
  output logic                         result_valid_o,
  output logic [rmq_pkg::RES_W-1:0]    minimum_o,
  output logic [rmq_pkg::STAT_W-1:0]   status_o
);

  import rmq_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = AW + 1;
  localparam int IW     = (CW > IDX_W) ? CW : IDX_W;
  localparam int BW     = BLOCK_BITS;
  localparam int MB     = 1 << BLOCK_BITS;
  localparam int VB     = VALUE_BITS;
  localparam int NBLK   = (DEPTH + MB - 1) >> BLOCK_BITS;
  localparam int NBW    = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int NB1    = NBW + 1;
  localparam int LEVELS = $clog2(NBLK + 1);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int KW     = LW + 1;

  function automatic logic [BW-1:0] low_bit(input logic [MB-1:0] m);
    logic [BW-1:0] r;
    r = '0;
    for (int i = MB - 1; i >= 0; i--) begin
      if (m[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] high_bit(input logic [MB-1:0] m);
    logic [BW-1:0] r;
    r = '0;
    for (int i = 0; i < MB; i++) begin
      if (m[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [LW-1:0] floor_log2(input logic [IW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < IW; i++) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MB-1:0] run_q, run_d;
  logic [MB-1:0] mask_q, mask_d;
  logic [VB-1:0] val_q, val_d;
  logic [VB-1:0] acc_q, acc_d;
  logic [VB-1:0] carry_q, carry_d;
  logic [IW-1:0] l_q, l_d, r_q, r_d, lu_q, lu_d, rd_q, rd_d;
  logic          single_q, single_d, head_q, head_d;
  logic [BW-1:0] t_q, t_d;
  logic [KW-1:0] k_q, k_d;
  logic [NBW-1:0] blk_q, blk_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          res_valid_q, res_valid_d;
  logic [VB-1:0] res_min_q, res_min_d;
  status_e       res_st_q, res_st_d;

  logic          accept;
  cmd_e          cmd;
  logic [IW-1:0] left_x, right_x, cnt_x, r_eff, lu_c, rd_c;
  logic          bad_range, empty_range, full, tail_go;
  logic [IW-1:0] ib_start, ib_end;
  logic [MB-1:0] ib_masked;
  logic [IW-1:0] sp_a, sp_c;
  logic [LW-1:0] sp_k;
  logic [NB1-1:0] blkp1, lv_j;
  logic [KW-1:0] k_next;
  logic          lv_more;
  logic [CW-1:0] base_c;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [VB-1:0] st_rvalue;
  logic [MB-1:0] st_rmask;
  logic          sp_we;
  logic [LW-1:0] sp_wlevel, sp_rlevel;
  logic [NBW-1:0] sp_wblock, sp_rblock;
  logic [VB-1:0] sp_rdata;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign cmd     = cmd_e'(command_i);
  assign left_x  = IW'(left_i);
  assign right_x = IW'(right_i);
  assign cnt_x   = IW'(cnt_q);
  assign r_eff   = (right_x > cnt_x) ? cnt_x : right_x;
  assign lu_c    = (left_x | IW'(MB - 1)) + IW'(1);
  assign rd_c    = r_eff & ~IW'(MB - 1);
  assign bad_range   = left_i > right_i;
  assign empty_range = left_x >= r_eff;
  assign full        = cnt_q >= CW'(DEPTH);
  assign tail_go     = rd_q < r_q;
  assign base_c      = cnt_q & ~CW'(MB - 1);

  assign ib_start  = head_q ? l_q : rd_q;
  assign ib_end    = (head_q && !single_q) ? lu_q : r_q;
  assign ib_masked = st_rmask & ({MB{1'b1}} << BW'(ib_start));

  assign sp_a = lu_q >> BW;
  assign sp_c = rd_q >> BW;
  assign sp_k = floor_log2(sp_c - sp_a);

  assign blkp1   = NB1'(blk_q) + NB1'(1);
  assign lv_j    = blkp1 - (NB1'(1) << k_q);
  assign k_next  = (state_q == S_C_L0D) ? KW'(1) : k_q + KW'(1);
  assign lv_more = (k_next < KW'(LEVELS)) && ((blkp1 >> k_next) != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_APPEND && !full) begin
            state_d = S_A_POP;
          end else if (cmd == CMD_QUERY && !bad_range && !empty_range) begin
            state_d = S_IB_M;
          end
        end
      end
      S_A_POP: state_d = (run_q == '0) ? S_A_WR : S_A_CMP;
      S_A_CMP: state_d = (val_q <= st_rvalue) ? S_A_POP : S_A_WR;
      S_A_WR:  state_d = (BW'(cnt_q) == BW'(MB - 1)) ? S_C_L0 : S_DONE;
      S_C_L0:  state_d = S_C_L0D;
      S_C_L0D: state_d = lv_more ? S_LV_RD : S_DONE;
      S_LV_RD: state_d = S_LV_WR;
      S_LV_WR: state_d = lv_more ? S_LV_RD : S_DONE;
      S_IB_M:  state_d = S_IB_V;
      S_IB_V:  state_d = S_IB_A;
      S_IB_A: begin
        if (head_q && !single_q) begin
          if (lu_q < rd_q) state_d = S_SP1;
          else if (tail_go) state_d = S_IB_M;
          else state_d = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SP1:   state_d = S_SP2;
      S_SP2:   state_d = S_SP3;
      S_SP3:   state_d = tail_go ? S_IB_M : S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d = cnt_q; run_d = run_q; mask_d = mask_q; val_d = val_q;
    acc_d = acc_q; carry_d = carry_q; l_d = l_q; r_d = r_q; lu_d = lu_q; rd_d = rd_q;
    single_d = single_q; head_d = head_q; t_d = t_q; k_d = k_q;
    blk_d = blk_q; pos_d = pos_q;
    res_valid_d = 1'b0; res_min_d = res_min_q; res_st_d = res_st_q;
    st_we = 1'b0; st_waddr = AW'(cnt_q); st_raddr = '0;
    sp_we = 1'b0; sp_wlevel = '0; sp_wblock = blk_q; sp_rlevel = '0; sp_rblock = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          acc_d = '1;
          val_d = VB'(value_i);
          res_min_d = '1;
          res_st_d = ST_OK;
          unique case (cmd)
            CMD_CLEAR: begin
              cnt_d = '0;
              run_d = '0;
              res_valid_d = 1'b1;
            end
            CMD_APPEND: begin
              if (full) begin
                res_st_d = ST_FULL;
                res_valid_d = 1'b1;
              end
            end
            CMD_QUERY: begin
              l_d = left_x;
              r_d = r_eff;
              lu_d = lu_c;
              rd_d = rd_c;
              single_d = lu_c > rd_c;
              head_d = 1'b1;
              if (bad_range) begin
                res_st_d = ST_BAD_RANGE;
                res_valid_d = 1'b1;
              end else if (empty_range) begin
                res_valid_d = 1'b1;
              end
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      S_A_POP: begin
        t_d = high_bit(run_q);
        st_raddr = AW'(base_c + CW'(high_bit(run_q)));
      end
      S_A_CMP: begin
        if (val_q <= st_rvalue) run_d = run_q & ~(MB'(1) << t_q);
      end
      S_A_WR: begin
        st_we = 1'b1;
        cnt_d = cnt_q + CW'(1);
        pos_d = AW'(cnt_q);
        blk_d = NBW'(cnt_q >> BW);
        mask_d = run_q;
        if (BW'(cnt_q) == BW'(MB - 1)) run_d = '0;
        else run_d = run_q | (MB'(1) << BW'(cnt_q));
      end
      S_C_L0: begin
        st_raddr = AW'((CW'(pos_q) & ~CW'(MB - 1)) + CW'(low_bit(mask_q)));
      end
      S_C_L0D: begin
        carry_d = (mask_q == '0) ? val_q : st_rvalue;
        sp_we = 1'b1;
        sp_wlevel = '0;
        sp_wblock = blk_q;
        k_d = KW'(1);
      end
      S_LV_RD: begin
        sp_rlevel = LW'(k_q - KW'(1));
        sp_rblock = NBW'(lv_j);
      end
      S_LV_WR: begin
        sp_we = 1'b1;
        sp_wlevel = LW'(k_q);
        sp_wblock = NBW'(lv_j);
        carry_d = (sp_rdata < carry_q) ? sp_rdata : carry_q;
        k_d = k_q + KW'(1);
      end
      S_IB_M: st_raddr = AW'(ib_end - IW'(1));
      S_IB_V: begin
        if (ib_masked == '0) st_raddr = AW'(ib_end - IW'(1));
        else st_raddr = AW'((ib_start & ~IW'(MB - 1)) + IW'(low_bit(ib_masked)));
      end
      S_IB_A: begin
        if (st_rvalue < acc_q) acc_d = st_rvalue;
        if (head_q && !single_q) head_d = 1'b0;
      end
      S_SP1: begin
        sp_rlevel = sp_k;
        sp_rblock = NBW'(sp_a);
      end
      S_SP2: begin
        if (sp_rdata < acc_q) acc_d = sp_rdata;
        sp_rlevel = sp_k;
        sp_rblock = NBW'(sp_c - (IW'(1) << sp_k));
      end
      S_SP3: begin
        if (sp_rdata < acc_q) acc_d = sp_rdata;
      end
      S_DONE: begin
        res_valid_d = 1'b1;
        res_min_d = acc_q;
        res_st_d = ST_OK;
      end
      default: ;
    endcase
  end

  logic [VB-1:0] sp_wdata;
  assign sp_wdata = (state_q == S_C_L0D) ? carry_d : ((sp_rdata < carry_q) ? sp_rdata : carry_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      run_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d; val_q <= val_d; acc_q <= acc_d; carry_q <= carry_d;
    l_q <= l_d; r_q <= r_d; lu_q <= lu_d; rd_q <= rd_d;
    single_q <= single_d; head_q <= head_d; t_q <= t_d; k_q <= k_d;
    blk_q <= blk_d; pos_q <= pos_d;
    res_min_q <= res_min_d; res_st_q <= res_st_d;
  end

  rmq_store #(
    .AW(AW),
    .VB(VB),
    .MB(MB)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (st_we),
    .wr_addr_i  (st_waddr),
    .wr_value_i (val_q),
    .wr_mask_i  (run_q),
    .rd_addr_i  (st_raddr),
    .rd_value_o (st_rvalue),
    .rd_mask_o  (st_rmask)
  );

  rmq_sparse #(
    .LW (LW),
    .NBW(NBW),
    .VB (VB)
  ) u_sparse (
    .clk_i      (clk_i),
    .wr_en_i    (sp_we),
    .wr_level_i (sp_wlevel),
    .wr_block_i (sp_wblock),
    .wr_data_i  (sp_wdata),
    .rd_level_i (sp_rlevel),
    .rd_block_i (sp_rblock),
    .rd_data_o  (sp_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign minimum_o      = RES_W'(res_min_q);
  assign status_o       = res_st_q;

endmodule

>>> rtl/core/rmq_checker.sv
// port-level checker for the range minimum query engine, bound to the top level
// uses rmq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [rmq_pkg::CMD_W-1:0]  command_i,
  input logic [rmq_pkg::DATA_W-1:0] value_i,
  input logic [rmq_pkg::IDX_W-1:0]  left_i,
  input logic [rmq_pkg::IDX_W-1:0]  right_i,
  input logic                       result_valid_o,
  input logic [rmq_pkg::RES_W-1:0]  minimum_o,
  input logic [rmq_pkg::STAT_W-1:0] status_o
);

  import rmq_pkg::*;

  logic acc;
  assign acc = start && !busy;

  `RMQ_ASSERT(a_clear_done, acc && command_i == CMD_CLEAR |=> result_valid_o && status_o == ST_OK, "clear gave no ok result")
  `RMQ_ASSERT(a_bad_range, acc && command_i == CMD_QUERY && left_i > right_i |=> result_valid_o && status_o == ST_BAD_RANGE, "bad range not flagged")
  `RMQ_ASSERT(a_full_cause, result_valid_o && status_o == ST_FULL |-> $past(acc && command_i == CMD_APPEND), "full status without append")
  `RMQ_ASSERT(a_result_cause, result_valid_o |-> $past(busy) || $past(acc), "result without request")
  `RMQ_ASSERT_ALWAYS(a_status_code, result_valid_o |-> status_o != 2'd3, "undefined status code")

endmodule

bind range_minimum_query_engine_core rmq_checker u_rmq_checker (.*);
